FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is asserted.
`define PFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define PFL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PFL_ASSERT(label, prop, msg)
`define PFL_ASSERT_RST(label, prop, msg)

`endif

`endif

FILE: rtl/pfl_pkg.sv
// Types, codes and field widths of the page free-list allocator.
package pfl_pkg;

  localparam int DEF_NUM_TABLES = 4;
  localparam int DEF_MAX_PAGES  = 32768;
  localparam int DEF_LINK_W     = 15;

  localparam int ACTION_W    = 2;
  localparam int TREQ_W      = 2;
  localparam int PAGE_W      = 15;
  localparam int TOTAL_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_W-1:0] INIT_PAGES_RST = 16'd2560;
  localparam logic [CFG_W-1:0] INIT_PAGES_MIN = 16'd2;

  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOTABLE = 2'd2,
    ST_BADPAGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_CHAIN,
    S_RESP
  } pfl_state_t;

endpackage

FILE: rtl/page_free_list_allocator.sv
// Page free-list allocator: one linked free-page list per table, links held in a single memory.
//
// One transaction is handled at a time; the result goes to an output register, so the next
// transaction is taken as soon as the previous result has moved there. An allocate from a
// non-empty list reads one link through the memory's registered port; a free, a create on an
// existing table, action code 3 and every rejected request go straight on to the response. The
// create of a new table writes n - 1 links, where n is initial_pages held to the range
// 2 .. MAX_PAGES, and an allocate that doubles a table writes as many links as its old page
// count; the new chain is written one link per cycle through the single memory port.
// The link memory has no reset and needs no clearing pass: only links of pages that have been
// chained or freed are ever read.
module page_free_list_allocator
  import pfl_pkg::*;
#(
  parameter int NUM_TABLES = DEF_NUM_TABLES,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: initial_pages.
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // tdata from bit 0: action[1:0], table_req[3:2], page[18:4], zero fill.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tdata from bit 0: granted_page[14:0], status[16:15], list_head[31:17], page_total[47:32].
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int LINK_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int MEM_DEPTH = NUM_TABLES * (2 ** LINK_W);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  pfl_state_t state_r, state_nxt;

  logic [ACTION_W-1:0] act_r;
  logic [TREQ_W-1:0]   tbl_r;
  logic [PAGE_W-1:0]   page_r;
  logic [CFG_W-1:0]    init_pages_r;

  logic [LINK_W-1:0]     free_head_r [NUM_TABLES];
  logic [CNT_W-1:0]      pages_r     [NUM_TABLES];
  logic [NUM_TABLES-1:0] created_r;

  logic [LINK_W-1:0] chain_p_r, chain_p_nxt;
  logic [LINK_W-1:0] chain_end_r, chain_end_nxt;
  logic [LINK_W-1:0] granted_r, granted_nxt;
  status_t           status_r, status_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_load;

  logic              fh_we, pg_we, cr_set;
  logic [LINK_W-1:0] fh_wdata;
  logic [CNT_W-1:0]  pg_wdata;

  logic              mem_en, mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [LINK_W-1:0] mem_wdata, mem_rdata;

  logic [TBL_W-1:0]  tidx;
  logic              tbl_ok, cur_created, grow_fail, page_bad, act_known;
  logic [LINK_W-1:0] cur_head;
  logic [CNT_W-1:0]  cur_pages, init_n;
  logic [CNT_W:0]    grown;
  logic [PAGE_W-1:0] rep_head;
  logic [TOTAL_W-1:0] rep_total;

  assign in_tready = (state_r == S_IDLE);

  // Lookups for the table of the transaction in progress.
  assign tidx        = TBL_W'(tbl_r);
  assign tbl_ok      = (32'(tbl_r) < NUM_TABLES);
  assign cur_created = tbl_ok && created_r[tidx];
  assign cur_head    = free_head_r[tidx];
  assign cur_pages   = pages_r[tidx];
  assign grown       = {1'b0, cur_pages} << 1;
  assign grow_fail   = (32'(grown) > MAX_PAGES);
  assign page_bad    = (page_r == '0) || (32'(page_r) >= 32'(cur_pages));
  assign act_known   = (act_r == ACT_CREATE) || (act_r == ACT_ALLOC) || (act_r == ACT_FREE);

  always_comb begin
    if (init_pages_r < INIT_PAGES_MIN) begin
      init_n = CNT_W'(INIT_PAGES_MIN);
    end else if (32'(init_pages_r) > MAX_PAGES) begin
      init_n = CNT_W'(MAX_PAGES);
    end else begin
      init_n = CNT_W'(init_pages_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chain_p_nxt   = chain_p_r;
    chain_end_nxt = chain_end_r;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    fh_we         = 1'b0;
    fh_wdata      = cur_head;
    pg_we         = 1'b0;
    pg_wdata      = cur_pages;
    cr_set        = 1'b0;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = MEM_AW'({tidx, chain_p_r});
    mem_wdata     = (chain_p_r == chain_end_r) ? '0 : chain_p_r + 1'b1;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        granted_nxt = '0;
        status_nxt  = ST_OK;
        state_nxt   = S_RESP;
        if (!tbl_ok) begin
          if (act_known) begin
            status_nxt = ST_NOTABLE;
          end
        end else begin
          case (act_r)
            ACT_CREATE: begin
              if (!cur_created) begin
                fh_we         = 1'b1;
                fh_wdata      = LINK_W'(1);
                pg_we         = 1'b1;
                pg_wdata      = init_n;
                cr_set        = 1'b1;
                chain_p_nxt   = LINK_W'(1);
                chain_end_nxt = LINK_W'(init_n - 1'b1);
                state_nxt     = S_CHAIN;
              end
            end
            ACT_ALLOC: begin
              if (!cur_created) begin
                status_nxt = ST_NOTABLE;
              end else if (cur_head == '0) begin
                if (grow_fail) begin
                  status_nxt = ST_NOSPACE;
                end else begin
                  // Old page count is the first new page; it is handed out at once.
                  pg_we         = 1'b1;
                  pg_wdata      = CNT_W'(grown);
                  fh_we         = 1'b1;
                  fh_wdata      = LINK_W'(cur_pages + 1'b1);
                  granted_nxt   = LINK_W'(cur_pages);
                  chain_p_nxt   = LINK_W'(cur_pages);
                  chain_end_nxt = LINK_W'(grown - 1'b1);
                  state_nxt     = S_CHAIN;
                end
              end else begin
                mem_en      = 1'b1;
                mem_addr    = MEM_AW'({tidx, cur_head});
                granted_nxt = cur_head;
                state_nxt   = S_RDWAIT;
              end
            end
            ACT_FREE: begin
              if (!cur_created) begin
                status_nxt = ST_NOTABLE;
              end else if (page_bad) begin
                status_nxt = ST_BADPAGE;
              end else begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = MEM_AW'({tidx, LINK_W'(page_r)});
                mem_wdata = cur_head;
                fh_we     = 1'b1;
                fh_wdata  = LINK_W'(page_r);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        fh_we     = 1'b1;
        fh_wdata  = mem_rdata;
        state_nxt = S_RESP;
      end
      S_CHAIN: begin
        mem_en      = 1'b1;
        mem_we      = 1'b1;
        chain_p_nxt = chain_p_r + 1'b1;
        if (chain_p_r == chain_end_r) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= in_tdata[ACTION_W-1:0];
      tbl_r  <= in_tdata[ACTION_W +: TREQ_W];
      page_r <= in_tdata[ACTION_W+TREQ_W +: PAGE_W];
    end
    chain_p_r   <= chain_p_nxt;
    chain_end_r <= chain_end_nxt;
    granted_r   <= granted_nxt;
    status_r    <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_pages_r <= INIT_PAGES_RST;
    end else if (cfg_we) begin
      init_pages_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      created_r <= '0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        free_head_r[i] <= '0;
        pages_r[i]     <= '0;
      end
    end else begin
      if (fh_we) begin
        free_head_r[tidx] <= fh_wdata;
      end
      if (pg_we) begin
        pages_r[tidx] <= pg_wdata;
      end
      if (cr_set) begin
        created_r[tidx] <= 1'b1;
      end
    end
  end

  pfl_link_mem #(
    .DATA_W (LINK_W),
    .DEPTH  (MEM_DEPTH)
  ) u_link_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Head and page count are reported only for a table that exists.
  assign rep_head  = cur_created ? PAGE_W'(cur_head) : '0;
  assign rep_total = cur_created ? TOTAL_W'(cur_pages) : '0;

  assign out_tvalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {rep_total, rep_head, status_r, PAGE_W'(granted_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `include "assert_macros.svh"

  `PFL_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_tvalid), "not idle after reset")
  `PFL_ASSERT(a_one_in_flight, (in_tvalid && in_tready) |=> !in_tready, "second transaction taken")
  `PFL_ASSERT(a_load_from_resp, $rose(out_tvalid) |-> $past(state_r == S_RESP), "result out of order")
  `PFL_ASSERT(a_chain_bound, (state_r == S_CHAIN) |-> (chain_p_r <= chain_end_r), "chain overrun")
  `PFL_ASSERT(a_head_in_range, (state_r == S_RESP && cur_created) |-> (32'(cur_head) < 32'(cur_pages)), "head beyond table")

endmodule

FILE: rtl/pfl_link_mem.sv
// Single-port synchronous link memory with a registered read.
module pfl_link_mem
  import pfl_pkg::*;
#(
  parameter int DATA_W = DEF_LINK_W,
  parameter int DEPTH  = DEF_NUM_TABLES * DEF_MAX_PAGES,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] link_mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      link_mem_r[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata_r <= link_mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
